@@ rtl/core/imubci_pkg.sv @@
package imubci_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COUNT_W  = 16;
   localparam int FACTOR_W = 16;
   localparam int GAIN_W   = 32;
   localparam int FIX_W    = 32;
   localparam int ANGLE_W  = 48;
   localparam int FRAC_W   = 16;
   localparam int GAIN_FRAC_W = 24;

   // bias-removed difference: raw << 16 minus a 32-bit bias, held in 34 bits signed
   localparam int DIFF_W = FIX_W + 2;
   // difference times zero-extended gain
   localparam int PROD_W = DIFF_W + GAIN_W + 1;
   // iir accumulator before the >> 16
   localparam int IIR_W  = FIX_W + FACTOR_W + 2;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 112;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_SMOOTHING_FACTOR = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACCEL_GAIN       = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GYRO_GAIN        = 2'd2;

   localparam logic [FACTOR_W-1:0] SMOOTHING_RESET = 16'd65143;
   localparam logic [GAIN_W-1:0]   GAIN_RESET      = 32'h0100_0000;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_START  = 1'b1;

   typedef struct packed {
      logic scale;        // sample measured outside calibration
      logic clear_angle;  // countdown reached zero on this sample
      logic calibrating;
   } stage_ctl_type;

   // floor(p / 2^24) saturated to signed 32 bits
   function automatic logic [FIX_W-1:0] scale_sat(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-GAIN_FRAC_W-1:0] q;
      logic [FIX_W-1:0] r;
      q = p[PROD_W-1:GAIN_FRAC_W];
      if (q[PROD_W-GAIN_FRAC_W-1:FIX_W-1] == '0 || q[PROD_W-GAIN_FRAC_W-1:FIX_W-1] == '1)
         r = q[FIX_W-1:0];
      else if (q[PROD_W-GAIN_FRAC_W-1])
         r = {1'b1, {(FIX_W-1){1'b0}}};
      else
         r = {1'b0, {(FIX_W-1){1'b1}}};
      return r;
   endfunction

endpackage

@@ rtl/core/imu_bias_calibrate_and_integrate.sv @@
// a result passes the stage 1, stage 2 and result registers on its way to rsp;
// one item per cycle while rsp is not stalled; stage 1 does the bias filter or the gain
// multiply, stage 2 saturates and adds into the 48-bit heading accumulator
// reset (synchronous, active high) zeroes offsets, countdown, heading and held
// outputs and loads the default smoothing factor and unity gains
module imu_bias_calibrate_and_integrate (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // accel_sample [15:0], gyro_sample [31:16], calib_count [47:32]
   input  logic [imubci_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd [0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // accel_scaled [31:0], gyro_scaled [63:32], angle_z [111:64]
   output logic [imubci_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // calibrating [0]
   output logic                               rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [imubci_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [imubci_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import imubci_pkg::*;

   // configuration
   logic [FACTOR_W-1:0] smooth_ff;
   logic [GAIN_W-1:0]   accel_gain_ff, gyro_gain_ff;

   // stage 1: input register
   logic                s1_v_ff, s1_v_in;
   logic                s1_cmd_ff;
   logic [SAMPLE_W-1:0] s1_accel_ff, s1_gyro_ff;
   logic [COUNT_W-1:0]  s1_count_ff;

   // filter state
   logic [SAMPLE_W-1:0] prev_accel_ff, prev_accel_in;
   logic [SAMPLE_W-1:0] prev_gyro_ff, prev_gyro_in;
   logic [FIX_W-1:0]    accel_bias_ff, accel_bias_in;
   logic [FIX_W-1:0]    gyro_bias_ff, gyro_bias_in;
   logic [COUNT_W-1:0]  calib_rem_ff, calib_rem_in;

   // stage 2: product register
   logic                      s2_v_ff, s2_v_in;
   stage_ctl_type             s2_ctl_ff, s2_ctl_in;
   logic signed [PROD_W-1:0]  s2_accel_prod_ff, s2_accel_prod_in;
   logic signed [PROD_W-1:0]  s2_gyro_prod_ff, s2_gyro_prod_in;

   // result register and held outputs
   logic                rsp_v_ff, rsp_v_in;
   logic                rsp_calib_ff;
   logic [FIX_W-1:0]    accel_hold_ff, accel_hold_in;
   logic [FIX_W-1:0]    gyro_hold_ff, gyro_hold_in;
   logic [ANGLE_W-1:0]  heading_ff, heading_in;

   logic rsp_en, s2_en, s1_en, s1_move, s2_move;

   logic [FACTOR_W:0]         weight;
   logic signed [IIR_W-1:0]   accel_iir, gyro_iir;
   logic signed [DIFF_W-1:0]  accel_diff, gyro_diff;
   logic [FIX_W-1:0]          accel_sat, gyro_sat;

   // stages advance into a free or draining slot
   assign rsp_en     = !rsp_v_ff || rsp_tready;
   assign s2_en      = !s2_v_ff || rsp_en;
   assign s1_en      = !s1_v_ff || s2_en;
   assign s1_move    = s1_v_ff && s2_en;
   assign s2_move    = s2_v_ff && rsp_en;
   assign req_tready = s1_en;
   assign csr_ready  = 1'b1;

   assign s1_v_in  = s1_en ? req_tvalid : s1_v_ff;
   assign s2_v_in  = s2_en ? s1_v_ff : s2_v_ff;
   assign rsp_v_in = rsp_en ? s2_v_ff : rsp_v_ff;

   // first-order iir: floor((bias*a + (raw<<16)*(65536-a)) / 65536)
   assign weight = (FACTOR_W+1)'(1 << FRAC_W) - {1'b0, smooth_ff};
   assign accel_iir =
      (IIR_W'($signed(accel_bias_ff)) * $signed({2'b0, smooth_ff})
       + ((IIR_W'($signed(s1_accel_ff)) * $signed({1'b0, weight})) <<< FRAC_W))
      >>> FRAC_W;
   assign gyro_iir =
      (IIR_W'($signed(gyro_bias_ff)) * $signed({2'b0, smooth_ff})
       + ((IIR_W'($signed(s1_gyro_ff)) * $signed({1'b0, weight})) <<< FRAC_W))
      >>> FRAC_W;

   assign accel_diff = $signed({{2{s1_accel_ff[SAMPLE_W-1]}}, s1_accel_ff, {FRAC_W{1'b0}}})
                       - DIFF_W'($signed(accel_bias_ff));
   assign gyro_diff  = $signed({{2{s1_gyro_ff[SAMPLE_W-1]}}, s1_gyro_ff, {FRAC_W{1'b0}}})
                       - DIFF_W'($signed(gyro_bias_ff));

   always_comb begin
      prev_accel_in     = prev_accel_ff;
      prev_gyro_in      = prev_gyro_ff;
      accel_bias_in     = accel_bias_ff;
      gyro_bias_in      = gyro_bias_ff;
      calib_rem_in      = calib_rem_ff;
      s2_ctl_in         = s2_ctl_ff;
      s2_accel_prod_in  = s2_accel_prod_ff;
      s2_gyro_prod_in   = s2_gyro_prod_ff;
      if (s1_move) begin
         s2_ctl_in.scale       = 1'b0;
         s2_ctl_in.clear_angle = 1'b0;
         s2_accel_prod_in = PROD_W'(accel_diff) * $signed({1'b0, accel_gain_ff});
         s2_gyro_prod_in  = PROD_W'(gyro_diff) * $signed({1'b0, gyro_gain_ff});
         if (s1_cmd_ff == CMD_START) begin
            // seed offsets from the last raw pair
            accel_bias_in = {prev_accel_ff, {FRAC_W{1'b0}}};
            gyro_bias_in  = {prev_gyro_ff, {FRAC_W{1'b0}}};
            calib_rem_in  = s1_count_ff;
         end else begin
            prev_accel_in = s1_accel_ff;
            prev_gyro_in  = s1_gyro_ff;
            if (calib_rem_ff != '0) begin
               calib_rem_in  = calib_rem_ff - COUNT_W'(1);
               accel_bias_in = accel_iir[FIX_W-1:0];
               gyro_bias_in  = gyro_iir[FIX_W-1:0];
               s2_ctl_in.clear_angle = (calib_rem_ff == COUNT_W'(1));
            end else begin
               s2_ctl_in.scale = 1'b1;
            end
         end
         s2_ctl_in.calibrating = (calib_rem_in != '0);
      end
   end

   assign accel_sat = scale_sat(s2_accel_prod_ff);
   assign gyro_sat  = scale_sat(s2_gyro_prod_ff);

   always_comb begin
      accel_hold_in = accel_hold_ff;
      gyro_hold_in  = gyro_hold_ff;
      heading_in    = heading_ff;
      if (s2_move) begin
         if (s2_ctl_ff.scale) begin
            accel_hold_in = accel_sat;
            gyro_hold_in  = gyro_sat;
            heading_in    = heading_ff + ANGLE_W'($signed(gyro_sat));
         end else if (s2_ctl_ff.clear_angle) begin
            heading_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff     <= SMOOTHING_RESET;
         accel_gain_ff <= GAIN_RESET;
         gyro_gain_ff  <= GAIN_RESET;
      end else if (csr_valid) begin
         case (csr_addr)
            CSR_SMOOTHING_FACTOR: smooth_ff     <= csr_wdata[FACTOR_W-1:0];
            CSR_ACCEL_GAIN:       accel_gain_ff <= csr_wdata[GAIN_W-1:0];
            CSR_GYRO_GAIN:        gyro_gain_ff  <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         rsp_v_ff      <= 1'b0;
         prev_accel_ff <= '0;
         prev_gyro_ff  <= '0;
         accel_bias_ff <= '0;
         gyro_bias_ff  <= '0;
         calib_rem_ff  <= '0;
         accel_hold_ff <= '0;
         gyro_hold_ff  <= '0;
         heading_ff    <= '0;
      end else begin
         s1_v_ff       <= s1_v_in;
         s2_v_ff       <= s2_v_in;
         rsp_v_ff      <= rsp_v_in;
         prev_accel_ff <= prev_accel_in;
         prev_gyro_ff  <= prev_gyro_in;
         accel_bias_ff <= accel_bias_in;
         gyro_bias_ff  <= gyro_bias_in;
         calib_rem_ff  <= calib_rem_in;
         accel_hold_ff <= accel_hold_in;
         gyro_hold_ff  <= gyro_hold_in;
         heading_ff    <= heading_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_cmd_ff   <= req_tuser;
         s1_accel_ff <= req_tdata[SAMPLE_W-1:0];
         s1_gyro_ff  <= req_tdata[2*SAMPLE_W-1:SAMPLE_W];
         s1_count_ff <= req_tdata[2*SAMPLE_W+COUNT_W-1:2*SAMPLE_W];
      end
      s2_ctl_ff        <= s2_ctl_in;
      s2_accel_prod_ff <= s2_accel_prod_in;
      s2_gyro_prod_ff  <= s2_gyro_prod_in;
      if (s2_move)
         rsp_calib_ff <= s2_ctl_ff.calibrating;
   end

   // held outputs only change when a beat moves into the result slot
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {heading_ff, gyro_hold_ff, accel_hold_ff};
   assign rsp_tuser  = rsp_calib_ff;

endmodule

@@ test/tb_imu_bias_calibrate_and_integrate.sv @@
module tb_imu_bias_calibrate_and_integrate;
   timeunit 1ns;
   timeprecision 1ps;

   import imubci_pkg::*;

   localparam int CLK_PERIOD       = 10;
   localparam int RESET_CYCLES     = 7;
   localparam int RANDOM_ITEMS     = 800;
   localparam int N_PHASES         = 6;
   localparam int STALL_LIMIT      = 2000;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int DRAIN_CYCLES     = 8;
   localparam int MAX_REPORTS      = 10;

   typedef struct packed {
      logic [FIX_W-1:0]   accel;
      logic [FIX_W-1:0]   gyro;
      logic [ANGLE_W-1:0] angle;
      logic               calibrating;
   } imu_out_type;

   typedef struct packed {
      logic                cmd;
      logic [SAMPLE_W-1:0] ax;
      logic [SAMPLE_W-1:0] gz;
      logic [COUNT_W-1:0]  cnt;
      logic                fixed_want;
      imu_out_type         want;
   } imu_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tuser  = CMD_SAMPLE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_ADDR_W-1:0]  csr_addr   = CSR_SMOOTHING_FACTOR;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // predictor state and its copy of the registers
   logic [FACTOR_W-1:0] cfg_retain     = SMOOTHING_RESET;
   logic [GAIN_W-1:0]   cfg_accel_gain = GAIN_RESET;
   logic [GAIN_W-1:0]   cfg_gyro_gain  = GAIN_RESET;
   logic [SAMPLE_W-1:0] last_ax   = '0;
   logic [SAMPLE_W-1:0] last_gz   = '0;
   logic [FIX_W-1:0]    accel_off = '0;
   logic [FIX_W-1:0]    gyro_off  = '0;
   logic [COUNT_W-1:0]  cal_left  = '0;
   logic [ANGLE_W-1:0]  angle_acc = '0;
   logic [FIX_W-1:0]    accel_out = '0;
   logic [FIX_W-1:0]    gyro_out  = '0;

   imu_out_type awaited_imu_out[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit long_hold_arm = 1'b0;
   int hold_left     = 0;

   int items_sent     = 0;
   int starts_sent    = 0;
   int measured_pairs = 0;
   int csr_writes     = 0;
   int results_seen   = 0;
   int mismatches     = 0;

   imu_bias_calibrate_and_integrate dut (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   // first-order smoothing of an offset towards a raw sample, floor division
   function automatic logic [FIX_W-1:0] smooth_bias(input logic signed [FIX_W-1:0] bias,
                                                    input logic signed [SAMPLE_W-1:0] raw);
      longint keep;
      longint acc;
      keep = longint'(cfg_retain);
      acc  = longint'(bias) * keep + longint'(raw) * 65536 * (65536 - keep);
      return FIX_W'(acc >>> FRAC_W);
   endfunction

   // bias removal and Q8.24 gain, floor, saturated to signed Q16.16
   function automatic logic [FIX_W-1:0] gain_scale(input logic signed [SAMPLE_W-1:0] raw,
                                                   input logic signed [FIX_W-1:0] bias,
                                                   input logic [GAIN_W-1:0] gain);
      longint diff;
      logic signed [97:0] prod;
      longint q;
      diff = longint'(raw) * 65536 - longint'(bias);
      prod = 98'(diff) * 98'($signed({1'b0, gain}));
      q    = longint'(prod >>> GAIN_FRAC_W);
      if (q > 64'sd2147483647)
         return 32'h7FFF_FFFF;
      if (q < -64'sd2147483648)
         return 32'h8000_0000;
      return q[FIX_W-1:0];
   endfunction

   function automatic imu_out_type advance_imu(input logic cmd,
                                               input logic [SAMPLE_W-1:0] ax,
                                               input logic [SAMPLE_W-1:0] gz,
                                               input logic [COUNT_W-1:0] cnt);
      imu_out_type res;
      if (cmd == CMD_START) begin
         accel_off = {last_ax, 16'h0000};
         gyro_off  = {last_gz, 16'h0000};
         cal_left  = cnt;
      end else begin
         last_ax = ax;
         last_gz = gz;
         if (cal_left != '0) begin
            cal_left  = cal_left - 1'b1;
            accel_off = smooth_bias(accel_off, ax);
            gyro_off  = smooth_bias(gyro_off, gz);
            if (cal_left == '0)
               angle_acc = '0;
         end else begin
            accel_out = gain_scale(ax, accel_off, cfg_accel_gain);
            gyro_out  = gain_scale(gz, gyro_off, cfg_gyro_gain);
            angle_acc = angle_acc + {{(ANGLE_W-FIX_W){gyro_out[FIX_W-1]}}, gyro_out};
            measured_pairs++;
         end
      end
      res.accel       = accel_out;
      res.gyro        = gyro_out;
      res.angle       = angle_acc;
      res.calibrating = (cal_left != '0);
      return res;
   endfunction

   function automatic imu_row_type dir_row(input logic cmd, input logic [SAMPLE_W-1:0] ax,
                                           input logic [SAMPLE_W-1:0] gz,
                                           input logic [COUNT_W-1:0] cnt,
                                           input logic fixed_want,
                                           input logic [FIX_W-1:0] accel,
                                           input logic [FIX_W-1:0] gyro,
                                           input logic [ANGLE_W-1:0] angle, input logic cal);
      imu_row_type r;
      r.cmd               = cmd;
      r.ax                = ax;
      r.gz                = gz;
      r.cnt               = cnt;
      r.fixed_want        = fixed_want;
      r.want.accel        = accel;
      r.want.gyro         = gyro;
      r.want.angle        = angle;
      r.want.calibrating  = cal;
      return r;
   endfunction

   // mostly small noise around a resting level, some full range, some rails
   function automatic logic [SAMPLE_W-1:0] pick_raw(input logic [SAMPLE_W-1:0] level);
      int pick;
      pick = $urandom_range(99);
      if (pick < 55)
         return level + 16'($urandom_range(128)) - 16'd64;
      if (pick < 85)
         return 16'($urandom);
      case ($urandom_range(3))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   task automatic offer_item(input logic cmd, input logic [SAMPLE_W-1:0] ax,
                             input logic [SAMPLE_W-1:0] gz, input logic [COUNT_W-1:0] cnt,
                             input logic fixed_want, input imu_out_type want);
      imu_out_type got;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {cnt, gz, ax};
      do @(posedge clock); while (!req_tready);
      got = advance_imu(cmd, ax, gz, cnt);
      awaited_imu_out.push_back(fixed_want ? want : got);
      items_sent++;
      if (cmd == CMD_START)
         starts_sent++;
   endtask

   task automatic random_item(input logic [SAMPLE_W-1:0] level_ax,
                              input logic [SAMPLE_W-1:0] level_gz);
      logic [SAMPLE_W-1:0] ax;
      logic [SAMPLE_W-1:0] gz;
      logic [COUNT_W-1:0]  cnt;
      int pick;
      ax  = pick_raw(level_ax);
      gz  = pick_raw(level_gz);
      cnt = 16'($urandom);
      if ($urandom_range(99) < 12) begin
         pick = $urandom_range(99);
         if (pick < 15)
            cnt = '0;
         else if (pick < 55)
            cnt = 16'($urandom_range(6, 1));
         else if (pick < 85)
            cnt = 16'($urandom_range(40, 7));
         else if (pick < 95)
            cnt = 16'($urandom_range(300, 41));
         offer_item(CMD_START, ax, gz, cnt, 1'b0, '0);
      end else begin
         offer_item(CMD_SAMPLE, ax, gz, cnt, 1'b0, '0);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (awaited_imu_out.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csrs(input int phase);
      logic [CSR_ADDR_W-1:0] idx[3];
      logic [CSR_DATA_W-1:0] vals[3];
      idx = '{CSR_SMOOTHING_FACTOR, CSR_ACCEL_GAIN, CSR_GYRO_GAIN};
      case (phase)
         1: vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
         2: vals = '{32'h0000_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
         3: vals = '{$urandom, $urandom_range(32'h0400_0000), $urandom_range(32'h0400_0000)};
         4: vals = '{$urandom_range(65535), $urandom, $urandom};
         default: vals = '{{16'h0000, SMOOTHING_RESET}, GAIN_RESET, GAIN_RESET};
      endcase
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_addr  <= idx[i];
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
         case (idx[i])
            CSR_SMOOTHING_FACTOR: cfg_retain     = vals[i][FACTOR_W-1:0];
            CSR_ACCEL_GAIN:       cfg_accel_gain = vals[i];
            CSR_GYRO_GAIN:        cfg_gyro_gain  = vals[i];
            default: ;
         endcase
         csr_writes++;
      end
      csr_valid <= 1'b0;
   endtask

   task automatic flag_mismatch(input string what, input logic [ANGLE_W-1:0] want,
                                input logic [ANGLE_W-1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch on %s, result %0d: expected %h, got %h",
                  what, results_seen, want, got);
   endtask

   always @(posedge clock) begin : rsp_side
      if (long_hold_arm) begin
         long_hold_arm = 1'b0;
         hold_left     = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      imu_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (awaited_imu_out.size() == 0) begin
            flag_mismatch("beat with nothing pending", '0, rsp_tdata[ANGLE_W-1:0]);
         end else begin
            want = awaited_imu_out.pop_front();
            if (rsp_tdata[FIX_W-1:0] !== want.accel)
               flag_mismatch("accel_scaled", ANGLE_W'(want.accel),
                             ANGLE_W'(rsp_tdata[FIX_W-1:0]));
            if (rsp_tdata[2*FIX_W-1:FIX_W] !== want.gyro)
               flag_mismatch("gyro_scaled", ANGLE_W'(want.gyro),
                             ANGLE_W'(rsp_tdata[2*FIX_W-1:FIX_W]));
            if (rsp_tdata[2*FIX_W+ANGLE_W-1:2*FIX_W] !== want.angle)
               flag_mismatch("angle_z", want.angle, rsp_tdata[2*FIX_W+ANGLE_W-1:2*FIX_W]);
            if (rsp_tuser !== want.calibrating)
               flag_mismatch("calibrating", ANGLE_W'(want.calibrating), ANGLE_W'(rsp_tuser));
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("timeout: no beat on any channel for %0d cycles, %0d results pending",
                     quiet, awaited_imu_out.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin : stimulus
      imu_row_type         rows[$];
      logic [SAMPLE_W-1:0] level_ax;
      logic [SAMPLE_W-1:0] level_gz;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 21;
      recv_idle_pct = 57;

      rows.push_back(dir_row(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h5555, 1'b1,
                             32'h0000_0000, 32'h0000_0000, 48'h0000_0000_0000, 1'b0));
      rows.push_back(dir_row(CMD_SAMPLE, 16'h0001, 16'hFFFF, 16'hAAAA, 1'b1,
                             32'h0001_0000, 32'hFFFF_0000, 48'hFFFF_FFFF_0000, 1'b0));
      // full-scale pairs with the offsets still at zero
      rows.push_back(dir_row(CMD_SAMPLE, 16'h7FFF, 16'h8000, 16'h0000, 1'b1,
                             32'h7FFF_0000, 32'h8000_0000, 48'hFFFF_7FFF_0000, 1'b0));
      rows.push_back(dir_row(CMD_SAMPLE, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1,
                             32'h8000_0000, 32'h7FFF_0000, 48'hFFFF_FFFE_0000, 1'b0));
      // zero-length calibration only seeds the offsets from the last pair
      rows.push_back(dir_row(CMD_START, 16'h1234, 16'h4321, 16'h0000, 1'b1,
                             32'h8000_0000, 32'h7FFF_0000, 48'hFFFF_FFFE_0000, 1'b0));
      rows.push_back(dir_row(CMD_SAMPLE, 16'h8000, 16'h7FFF, 16'h0000, 1'b1,
                             32'h0000_0000, 32'h0000_0000, 48'hFFFF_FFFE_0000, 1'b0));
      // offsets on the opposite rails, both channels saturate
      rows.push_back(dir_row(CMD_SAMPLE, 16'h7FFF, 16'h8000, 16'h0000, 1'b1,
                             32'h7FFF_FFFF, 32'h8000_0000, 48'hFFFF_7FFE_0000, 1'b0));
      // short calibration, heading cleared on the last countdown sample
      rows.push_back(dir_row(CMD_START, 16'hFFFF, 16'hFFFF, 16'h0003, 1'b0, '0, '0, '0, 1'b0));
      repeat (3)
         rows.push_back(dir_row(CMD_SAMPLE, 16'h0064, 16'hFF38, 16'hFFFF, 1'b0,
                                '0, '0, '0, 1'b0));
      rows.push_back(dir_row(CMD_SAMPLE, 16'h7FFF, 16'h8000, 16'h0000, 1'b0, '0, '0, '0, 1'b0));
      rows.push_back(dir_row(CMD_START, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, '0, '0, '0, 1'b0));
      rows.push_back(dir_row(CMD_SAMPLE, 16'hFFFF, 16'h0001, 16'h0000, 1'b0, '0, '0, '0, 1'b0));
      // restart while counting
      rows.push_back(dir_row(CMD_START, 16'h8000, 16'h7FFF, 16'h0002, 1'b0, '0, '0, '0, 1'b0));
      repeat (2)
         rows.push_back(dir_row(CMD_SAMPLE, 16'h0005, 16'hFFFB, 16'h0000, 1'b0,
                                '0, '0, '0, 1'b0));
      rows.push_back(dir_row(CMD_START, 16'h0000, 16'h0000, 16'h0001, 1'b0, '0, '0, '0, 1'b0));
      // zero count while counting ends calibration at once
      rows.push_back(dir_row(CMD_START, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0, '0, '0, 1'b0));
      rows.push_back(dir_row(CMD_SAMPLE, 16'h1234, 16'hEDCC, 16'h0000, 1'b0, '0, '0, '0, 1'b0));
      rows.push_back(dir_row(CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, '0, '0, '0, 1'b0));

      foreach (rows[i])
         offer_item(rows[i].cmd, rows[i].ax, rows[i].gz, rows[i].cnt,
                    rows[i].fixed_want, rows[i].want);

      for (int phase = 0; phase < N_PHASES; phase++) begin
         if (phase > 0) begin
            drain_results();
            write_csrs(phase);
         end
         case (phase / 2)
            0: begin
               send_idle_pct = 21;
               recv_idle_pct = 57;
            end
            1: begin
               send_idle_pct = 57;
               recv_idle_pct = 21;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         // sink goes quiet for a long stretch so the pipe backs up into req
         if (phase == 1)
            long_hold_arm = 1'b1;
         level_ax = 16'($urandom);
         level_gz = 16'($urandom);
         repeat (RANDOM_ITEMS / N_PHASES)
            random_item(level_ax, level_gz);
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items (%0d calibration starts, %0d measured pairs), %0d results checked",
               items_sent, starts_sent, measured_pairs, results_seen);
      $display("%0d register writes over %0d settings, %0d mismatches",
               csr_writes, N_PHASES, mismatches);
      if (mismatches == 0 && awaited_imu_out.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
